// ===== src/ews_pkg.sv =====
package ews_pkg;

  // Default widths of the ticker and of the extended total
  localparam int TICK_BITS_DEF  = 32;
  localparam int TOTAL_BITS_DEF = 64;

  localparam int CMD_W    = 4;
  localparam int STATUS_W = 3;

  // Command codes as they arrive on the request channel
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT      = 4'd0,
    CMD_RELEASE   = 4'd1,
    CMD_START     = 4'd2,
    CMD_STOP      = 4'd3,
    CMD_RESET     = 4'd4,
    CMD_READ_US   = 4'd5,
    CMD_READ_MS   = 4'd6,
    CMD_QUERY_RUN = 4'd7,
    CMD_POLL      = 4'd8
  } cmd_t;

  // Decoded operation, unused codes fold into OP_NOP
  typedef enum logic [3:0] {
    OP_INIT,
    OP_RELEASE,
    OP_START,
    OP_STOP,
    OP_RESET,
    OP_READ_US,
    OP_READ_MS,
    OP_QUERY_RUN,
    OP_POLL,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 3'd0,
    ST_NOT_INIT         = 3'd1,
    ST_ALREADY_INIT     = 3'd2,
    ST_ALREADY_RELEASED = 3'd3,
    ST_ALREADY_RUNNING  = 3'd4,
    ST_ALREADY_STOPPED  = 3'd5
  } status_t;

  // Control fields that travel with each response through the back end
  typedef struct packed {
    status_t status;
    logic    running;
    logic    is_ms;
  } rsp_ctl_t;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Divide by 1000, one 16-bit digit at a time with a reciprocal estimate
  localparam int DIV_BASE  = 1000;
  localparam int DIG_W     = 16;
  localparam int REM_W     = 10;
  localparam int VW        = REM_W + DIG_W;
  localparam int DIV_SHIFT = 36;
  localparam int RECIP_W   = 27;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719476;
  localparam int PW        = VW + RECIP_W;

  function automatic op_t decode_cmd(input logic [CMD_W-1:0] cmd);
    op_t op;
    unique case (cmd)
      CMD_INIT:      op = OP_INIT;
      CMD_RELEASE:   op = OP_RELEASE;
      CMD_START:     op = OP_START;
      CMD_STOP:      op = OP_STOP;
      CMD_RESET:     op = OP_RESET;
      CMD_READ_US:   op = OP_READ_US;
      CMD_READ_MS:   op = OP_READ_MS;
      CMD_QUERY_RUN: op = OP_QUERY_RUN;
      CMD_POLL:      op = OP_POLL;
      default:       op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== src/ews_req_if.sv =====
interface ews_req_if #(
  parameter int TICK_BITS = ews_pkg::TICK_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ews_pkg::CMD_W-1:0]  cmd;
  logic [TICK_BITS-1:0]       tick_now;

  modport source (output valid, cmd, tick_now, input ready);
  modport sink (input valid, cmd, tick_now, output ready);
endinterface

// ===== src/ews_rsp_if.sv =====
interface ews_rsp_if #(
  parameter int TOTAL_BITS = ews_pkg::TOTAL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [ews_pkg::STATUS_W-1:0] status;
  logic [TOTAL_BITS-1:0]        time_value;
  logic                         is_running;

  modport source (output valid, status, time_value, is_running, input ready);
  modport sink (input valid, status, time_value, is_running, output ready);
endinterface

// ===== src/ews_front.sv =====
module ews_front #(
  parameter int TICK_BITS = ews_pkg::TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ews_pkg::CMD_W-1:0] in_cmd,
  input  logic [TICK_BITS-1:0] in_tick,
  output logic                 head_valid,
  output ews_pkg::op_t         head_op,
  output logic [TICK_BITS-1:0] head_tick,
  input  logic                 pop
);

  ews_pkg::op_t               q_op   [ews_pkg::QDEPTH];
  logic [TICK_BITS-1:0]       q_tick [ews_pkg::QDEPTH];
  logic [ews_pkg::QAW-1:0]    wr_ptr;
  logic [ews_pkg::QAW-1:0]    rd_ptr;
  logic [ews_pkg::QCW-1:0]    count;
  logic                       push;

  assign in_ready   = (count != ews_pkg::QCW'(ews_pkg::QDEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign head_op    = q_op[rd_ptr];
  assign head_tick  = q_tick[rd_ptr];

  // queue storage, classified on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]   <= ews_pkg::decode_cmd(in_cmd);
      q_tick[wr_ptr] <= in_tick;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/ews_exec.sv =====
module ews_exec #(
  parameter int TICK_BITS  = ews_pkg::TICK_BITS_DEF,
  parameter int TOTAL_BITS = ews_pkg::TOTAL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  head_valid,
  input  ews_pkg::op_t          head_op,
  input  logic [TICK_BITS-1:0]  head_tick,
  output logic                  pop,
  output logic                  out_valid,
  output ews_pkg::rsp_ctl_t     out_ctl,
  output logic [TOTAL_BITS-1:0] out_total
);

  logic                  initialized, initialized_next;
  logic                  running, running_next;
  logic [TICK_BITS-1:0]  last_tick, last_tick_next;
  logic [TOTAL_BITS-1:0] total, total_next;
  logic [TOTAL_BITS-1:0] acc_total;
  logic [TICK_BITS-1:0]  delta;
  ews_pkg::status_t      st;
  logic                  rd;
  logic                  ms;

  assign pop       = adv && head_valid;
  assign delta     = head_tick - last_tick;
  assign acc_total = total + TOTAL_BITS'(delta);

  // command execution against the stopwatch state
  always_comb begin
    initialized_next = initialized;
    running_next     = running;
    last_tick_next   = last_tick;
    total_next       = total;
    st               = ews_pkg::ST_OK;
    rd               = 1'b0;
    ms               = 1'b0;
    unique case (head_op)
      ews_pkg::OP_INIT: begin
        if (initialized) begin
          st = ews_pkg::ST_ALREADY_INIT;
        end else begin
          running_next     = 1'b0;
          last_tick_next   = '0;
          total_next       = '0;
          initialized_next = 1'b1;
        end
      end
      ews_pkg::OP_RELEASE: begin
        if (!initialized) begin
          st = ews_pkg::ST_ALREADY_RELEASED;
        end else begin
          running_next     = 1'b0;
          last_tick_next   = '0;
          total_next       = '0;
          initialized_next = 1'b0;
        end
      end
      ews_pkg::OP_START: begin
        if (!initialized) begin
          st = ews_pkg::ST_NOT_INIT;
        end else if (running) begin
          st = ews_pkg::ST_ALREADY_RUNNING;
        end else begin
          last_tick_next = head_tick;
          running_next   = 1'b1;
        end
      end
      ews_pkg::OP_STOP: begin
        if (!initialized) begin
          st = ews_pkg::ST_NOT_INIT;
        end else if (!running) begin
          st = ews_pkg::ST_ALREADY_STOPPED;
        end else begin
          total_next     = acc_total;
          last_tick_next = head_tick;
          running_next   = 1'b0;
        end
      end
      ews_pkg::OP_RESET: begin
        if (!initialized) begin
          st = ews_pkg::ST_NOT_INIT;
        end else begin
          if (running) last_tick_next = head_tick;
          total_next = '0;
        end
      end
      ews_pkg::OP_READ_US, ews_pkg::OP_READ_MS: begin
        if (!initialized) begin
          st = ews_pkg::ST_NOT_INIT;
        end else begin
          if (running) begin
            total_next     = acc_total;
            last_tick_next = head_tick;
          end
          rd = 1'b1;
          ms = (head_op == ews_pkg::OP_READ_MS);
        end
      end
      ews_pkg::OP_QUERY_RUN: begin
        if (!initialized) st = ews_pkg::ST_NOT_INIT;
      end
      ews_pkg::OP_POLL: begin
        if (!initialized) begin
          st = ews_pkg::ST_NOT_INIT;
        end else if (running) begin
          total_next     = acc_total;
          last_tick_next = head_tick;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initialized <= 1'b0;
      running     <= 1'b0;
      last_tick   <= '0;
      total       <= '0;
    end else if (pop) begin
      initialized <= initialized_next;
      running     <= running_next;
      last_tick   <= last_tick_next;
      total       <= total_next;
    end
  end

  // response stage into the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl.status  <= st;
      out_ctl.running <= running_next;
      out_ctl.is_ms   <= ms;
      out_total       <= rd ? total_next : '0;
    end
  end

endmodule

// ===== src/ews_div.sv =====
module ews_div #(
  parameter int TOTAL_BITS = ews_pkg::TOTAL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  ews_pkg::rsp_ctl_t     in_ctl,
  input  logic [TOTAL_BITS-1:0] in_total,
  output logic                  out_valid,
  output ews_pkg::rsp_ctl_t     out_ctl,
  output logic [TOTAL_BITS-1:0] out_value
);

  localparam int NDIG = (TOTAL_BITS + ews_pkg::DIG_W - 1) / ews_pkg::DIG_W;
  localparam int PADW = NDIG * ews_pkg::DIG_W;

  // stage inputs per digit
  logic                       sv   [NDIG];
  ews_pkg::rsp_ctl_t          sctl [NDIG];
  logic [PADW-1:0]            sx   [NDIG];
  logic [PADW-1:0]            sq   [NDIG];
  logic [ews_pkg::REM_W-1:0]  sr   [NDIG];

  // estimate stage registers
  logic                       a_v   [NDIG];
  ews_pkg::rsp_ctl_t          a_ctl [NDIG];
  logic [PADW-1:0]            a_x   [NDIG];
  logic [PADW-1:0]            a_q   [NDIG];
  logic [ews_pkg::VW-1:0]     a_n   [NDIG];
  logic [ews_pkg::DIG_W-1:0]  a_qe  [NDIG];

  // correction stage registers
  logic                       b_v   [NDIG];
  ews_pkg::rsp_ctl_t          b_ctl [NDIG];
  logic [PADW-1:0]            b_x   [NDIG];
  logic [PADW-1:0]            b_q   [NDIG];
  logic [ews_pkg::REM_W-1:0]  b_r   [NDIG];

  for (genvar i = 0; i < NDIG; i++) begin : g_dig
    logic [ews_pkg::VW-1:0]    v;
    logic [ews_pkg::PW-1:0]    prod;
    logic [ews_pkg::VW-1:0]    rm;
    logic [ews_pkg::VW-1:0]    rn;
    logic                      ge;
    logic [ews_pkg::DIG_W-1:0] q_dig;

    if (i == 0) begin : g_first
      assign sv[i]   = in_valid;
      assign sctl[i] = in_ctl;
      assign sx[i]   = PADW'(in_total);
      assign sq[i]   = '0;
      assign sr[i]   = '0;
    end else begin : g_next
      assign sv[i]   = b_v[i-1];
      assign sctl[i] = b_ctl[i-1];
      assign sx[i]   = b_x[i-1];
      assign sq[i]   = b_q[i-1];
      assign sr[i]   = b_r[i-1];
    end

    // partial dividend and reciprocal estimate, may be one short
    assign v    = {sr[i], sx[i][PADW-1-ews_pkg::DIG_W*i -: ews_pkg::DIG_W]};
    assign prod = ews_pkg::PW'(v) * ews_pkg::PW'(ews_pkg::DIV_RECIP);

    // remainder check and one-step correction
    assign rm    = a_n[i] - ews_pkg::VW'(a_qe[i]) * ews_pkg::VW'(ews_pkg::DIV_BASE);
    assign ge    = (rm >= ews_pkg::VW'(ews_pkg::DIV_BASE));
    assign rn    = ge ? rm - ews_pkg::VW'(ews_pkg::DIV_BASE) : rm;
    assign q_dig = a_qe[i] + ews_pkg::DIG_W'(ge);

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[i] <= 1'b0;
        b_v[i] <= 1'b0;
      end else if (adv) begin
        a_v[i] <= sv[i];
        b_v[i] <= a_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_ctl[i] <= sctl[i];
        a_x[i]   <= sx[i];
        a_q[i]   <= sq[i];
        a_n[i]   <= v;
        a_qe[i]  <= prod[ews_pkg::DIV_SHIFT +: ews_pkg::DIG_W];
        b_ctl[i] <= a_ctl[i];
        b_x[i]   <= a_x[i];
        b_q[i]   <= a_q[i] | (PADW'(q_dig) << (ews_pkg::DIG_W * (NDIG - 1 - i)));
        b_r[i]   <= rn[ews_pkg::REM_W-1:0];
      end
    end
  end

  // last correction stage is the output register
  assign out_valid = b_v[NDIG-1];
  assign out_ctl   = b_ctl[NDIG-1];
  assign out_value = b_ctl[NDIG-1].is_ms ? b_q[NDIG-1][TOTAL_BITS-1:0]
                                         : b_x[NDIG-1][TOTAL_BITS-1:0];

endmodule

// ===== src/wrap_extending_stopwatch_64_core.sv =====
// Stopwatch extending a free-running microsecond ticker into a wide total.
// Request channel (req): cmd and tick_now; one response per request on rsp
// with status, time_value (us or ms for reads, else zero) and is_running.
// Both channels use valid/ready; a request moves when both are high.
// A request passes the queue, the execution register and the divider
// stages to rsp.valid. Throughput is one request per cycle unless rsp
// stalls: the state update is a single subtract and add, and the divide by
// 1000 is a pipeline of two stages per 16-bit digit, one multiply in each.
// A two-entry queue sits between the decode front and the execution back.
// While a response waits on rsp with rsp.ready low, the whole back end
// holds and the response stays put; the queue keeps taking requests until
// it is full, at which point req.ready drops. With rsp.valid low the back
// end keeps moving. Reset (rst, synchronous) clears the stopwatch to
// uninitialised and stopped with a zero total, and empties the queue and
// pipeline; no response is shown in the cycle after reset.
module wrap_extending_stopwatch_64_core #(
  parameter int TICK_BITS  = ews_pkg::TICK_BITS_DEF,
  parameter int TOTAL_BITS = ews_pkg::TOTAL_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ews_req_if.sink   req,
  ews_rsp_if.source rsp
);

  logic                  adv;
  logic                  head_valid;
  ews_pkg::op_t          head_op;
  logic [TICK_BITS-1:0]  head_tick;
  logic                  pop;
  logic                  e_valid;
  ews_pkg::rsp_ctl_t     e_ctl;
  logic [TOTAL_BITS-1:0] e_total;
  ews_pkg::rsp_ctl_t     o_ctl;

  // back end moves whenever the output slot is free or being taken
  assign adv = !rsp.valid || rsp.ready;

  ews_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_cmd     (req.cmd),
    .in_tick    (req.tick_now),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_tick  (head_tick),
    .pop        (pop)
  );

  ews_exec #(.TICK_BITS(TICK_BITS), .TOTAL_BITS(TOTAL_BITS)) u_exec (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_tick  (head_tick),
    .pop        (pop),
    .out_valid  (e_valid),
    .out_ctl    (e_ctl),
    .out_total  (e_total)
  );

  ews_div #(.TOTAL_BITS(TOTAL_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (e_valid),
    .in_ctl     (e_ctl),
    .in_total   (e_total),
    .out_valid  (rsp.valid),
    .out_ctl    (o_ctl),
    .out_value  (rsp.time_value)
  );

  assign rsp.status     = o_ctl.status;
  assign rsp.is_running = o_ctl.running;

endmodule

// ===== src/ews_check.sv =====
module ews_check #(
  parameter int TOTAL_BITS = ews_pkg::TOTAL_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ews_pkg::STATUS_W-1:0] rsp_status,
  input logic [TOTAL_BITS-1:0]        rsp_time_value,
  input logic                         rsp_is_running
);

  // a held response keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_time_value) && $stable(rsp_is_running))
    else $error("response changed while stalled");

  // nothing comes out in the cycle after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a failed command reports no time
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ews_pkg::ST_OK |-> rsp_time_value == '0)
    else $error("time value on failed command");

  // an uninitialised stopwatch cannot be running
  a_uninit_stopped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ews_pkg::ST_NOT_INIT
      || rsp_status == ews_pkg::ST_ALREADY_RELEASED) |-> !rsp_is_running)
    else $error("running while not initialised");

  // already-running and already-stopped agree with the running flag
  a_run_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ews_pkg::ST_ALREADY_RUNNING
      || rsp_status == ews_pkg::ST_ALREADY_STOPPED)
      |-> rsp_is_running == (rsp_status == ews_pkg::ST_ALREADY_RUNNING))
    else $error("running flag contradicts status");

endmodule

bind wrap_extending_stopwatch_64_core ews_check #(.TOTAL_BITS(TOTAL_BITS)) u_ews_check (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_time_value (rsp.time_value),
  .rsp_is_running (rsp.is_running)
);

// ===== tb/testbench.sv =====
module testbench;
  import ews_pkg::*;

  localparam int TICK_W      = TICK_BITS_DEF;
  localparam int TOTAL_W     = TOTAL_BITS_DEF;
  // Acceptance to response, used to size the final drain wait
  localparam int LATENCY     = 1 + 2 * ((TOTAL_W + 15) / 16);
  localparam int RANDOM_REQS = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  // Command codes the core ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    status_t            status;
    logic [TOTAL_W-1:0] time_value;
    logic               is_running;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TICK_W-1:0] tick;
    logic              typed;
    reply_t            reply;
  } stim_row_t;

  localparam reply_t NO_REPLY = '{ST_OK, '0, 1'b0};

  // Directed requests; rows with typed set carry their own expected reply
  localparam stim_row_t DIRECTED [26] = '{
    '{CMD_READ_US,   32'h0000_0000, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_RELEASE,   32'h0000_0000, 1'b1, '{ST_ALREADY_RELEASED, '0, 1'b0}},
    '{CMD_START,     32'h0000_1234, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_STOP,      32'hFFFF_FFFF, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_RESET,     32'h0000_0000, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_QUERY_RUN, 32'h0000_0000, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_POLL,      32'hFFFF_FFFF, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_READ_MS,   32'h0000_0000, 1'b1, '{ST_NOT_INIT,         '0, 1'b0}},
    '{CMD_SPARE_HI,  32'hFFFF_FFFF, 1'b1, '{ST_OK,               '0, 1'b0}},
    '{CMD_INIT,      32'hFFFF_FFFF, 1'b1, '{ST_OK,               '0, 1'b0}},
    '{CMD_INIT,      32'h0000_0000, 1'b1, '{ST_ALREADY_INIT,     '0, 1'b0}},
    '{CMD_STOP,      32'h0000_0000, 1'b1, '{ST_ALREADY_STOPPED,  '0, 1'b0}},
    '{CMD_POLL,      32'h5555_5555, 1'b1, '{ST_OK,               '0, 1'b0}},
    '{CMD_READ_US,   32'hAAAA_AAAA, 1'b1, '{ST_OK,               '0, 1'b0}},
    '{CMD_START,     32'hFFFF_FFF0, 1'b1, '{ST_OK,               '0, 1'b1}},
    '{CMD_START,     32'h0000_0000, 1'b1, '{ST_ALREADY_RUNNING,  '0, 1'b1}},
    '{CMD_POLL,      32'h0000_0010, 1'b0, NO_REPLY},
    '{CMD_READ_US,   32'h0000_0030, 1'b0, NO_REPLY},
    '{CMD_RESET,     32'hFFFF_FFFF, 1'b0, NO_REPLY},
    '{CMD_READ_MS,   32'h0001_869F, 1'b0, NO_REPLY},
    '{CMD_QUERY_RUN, 32'h0000_0000, 1'b0, NO_REPLY},
    '{CMD_SPARE_LO,  32'h1234_5678, 1'b0, NO_REPLY},
    '{CMD_POLL,      32'h7FFF_FFFF, 1'b0, NO_REPLY},
    '{CMD_STOP,      32'h8000_0000, 1'b0, NO_REPLY},
    '{CMD_READ_MS,   32'hFFFF_FFFF, 1'b0, NO_REPLY},
    '{CMD_RELEASE,   32'h0000_0000, 1'b1, '{ST_OK,               '0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;

  always #5 clk = ~clk;

  ews_req_if req_ch ();
  ews_rsp_if rsp_ch ();

  wrap_extending_stopwatch_64_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Stopwatch state as the core should hold it
  logic               sw_init    = 1'b0;
  logic               sw_running = 1'b0;
  logic [TICK_W-1:0]  sw_ref     = '0;
  logic [TOTAL_W-1:0] sw_total   = '0;

  reply_t replies_due [$];
  int     fail_count = 0;

  // Add ticks elapsed since the reference, wrapping at the ticker width
  function automatic void fold_ticks(input logic [TICK_W-1:0] tick);
    logic [TICK_W-1:0] delta;
    delta    = tick - sw_ref;
    sw_total = sw_total + TOTAL_W'(delta);
    sw_ref   = tick;
  endfunction

  // Apply one request to the stopwatch state and return its reply
  function automatic reply_t stopwatch_step(input logic [CMD_W-1:0] cmd,
                                            input logic [TICK_W-1:0] tick);
    reply_t r;
    r.status     = ST_OK;
    r.time_value = '0;
    case (cmd)
      CMD_INIT: begin
        if (sw_init) begin
          r.status = ST_ALREADY_INIT;
        end else begin
          sw_running = 1'b0;
          sw_ref     = '0;
          sw_total   = '0;
          sw_init    = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (!sw_init) begin
          r.status = ST_ALREADY_RELEASED;
        end else begin
          sw_running = 1'b0;
          sw_ref     = '0;
          sw_total   = '0;
          sw_init    = 1'b0;
        end
      end
      CMD_START: begin
        if (!sw_init) begin
          r.status = ST_NOT_INIT;
        end else if (sw_running) begin
          r.status = ST_ALREADY_RUNNING;
        end else begin
          sw_ref     = tick;
          sw_running = 1'b1;
        end
      end
      CMD_STOP: begin
        if (!sw_init) begin
          r.status = ST_NOT_INIT;
        end else if (!sw_running) begin
          r.status = ST_ALREADY_STOPPED;
        end else begin
          fold_ticks(tick);
          sw_running = 1'b0;
        end
      end
      CMD_RESET: begin
        if (!sw_init) begin
          r.status = ST_NOT_INIT;
        end else begin
          if (sw_running) sw_ref = tick;
          sw_total = '0;
        end
      end
      CMD_READ_US, CMD_READ_MS: begin
        if (!sw_init) begin
          r.status = ST_NOT_INIT;
        end else begin
          if (sw_running) fold_ticks(tick);
          r.time_value = (cmd == CMD_READ_US) ? sw_total
                                              : sw_total / TOTAL_W'(DIV_BASE);
        end
      end
      CMD_QUERY_RUN: begin
        if (!sw_init) r.status = ST_NOT_INIT;
      end
      CMD_POLL: begin
        if (!sw_init) r.status = ST_NOT_INIT;
        else if (sw_running) fold_ticks(tick);
      end
      default: ;
    endcase
    r.is_running = sw_running;
    return r;
  endfunction

  // Mostly no pause, some short ones, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Present one request and hold it until the core takes it
  task automatic issue_request(input logic [CMD_W-1:0] cmd,
                               input logic [TICK_W-1:0] tick,
                               input logic typed, input reply_t typed_reply);
    int unsigned gap;
    reply_t      predicted;
    gap = calm ? 0 : idle_length();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= cmd;
    req_ch.tick_now <= tick;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = stopwatch_step(cmd, tick);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  // Compare a response against the oldest outstanding request
  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: response with no request pending: status %0d value %h running %b",
                 $time, rsp_ch.status, rsp_ch.time_value, rsp_ch.is_running);
      fail_count++;
    end else begin
      want = replies_due.pop_front();
      if (rsp_ch.status !== want.status || rsp_ch.time_value !== want.time_value ||
          rsp_ch.is_running !== want.is_running) begin
        if (fail_count < MAX_REPORTS)
          $display({"%0t: response mismatch: expected status %0d value %h running %b,",
                    " got status %0d value %h running %b"},
                   $time, want.status, want.time_value, want.is_running,
                   rsp_ch.status, rsp_ch.time_value, rsp_ch.is_running);
        fail_count++;
      end
    end
  endtask

  // Response side: check on each handshake, stall ready at random
  int unsigned ready_hold = 0;
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_reply();
    if (ready_hold != 0) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      ready_hold   <= calm ? 0 : idle_length();
    end
  end

  // Watchdog: too long with no handshake on either channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] wall_tick;
    int unsigned       r;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = '0;
    req_ch.tick_now = '0;
    wall_tick       = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++)
      issue_request(DIRECTED[i].cmd, DIRECTED[i].tick, DIRECTED[i].typed,
                    DIRECTED[i].reply);

    // Random requests, mostly sensible for the current state
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) wall_tick = wall_tick + $urandom_range(0, 1500);
      else if (r < 88) wall_tick = wall_tick + $urandom_range(0, 32'h00FF_FFFF);
      else wall_tick = wall_tick + $urandom();
      tick = wall_tick;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: any code, any tick
        cmd  = CMD_W'($urandom_range(0, 15));
        tick = $urandom();
      end else begin
        r = $urandom_range(0, 99);
        if (!sw_init) begin
          cmd = (r < 85) ? CMD_INIT : CMD_W'($urandom_range(0, 8));
        end else if (!sw_running) begin
          if (r < 45)      cmd = CMD_START;
          else if (r < 57) cmd = CMD_READ_US;
          else if (r < 69) cmd = CMD_READ_MS;
          else if (r < 75) cmd = CMD_QUERY_RUN;
          else if (r < 81) cmd = CMD_POLL;
          else if (r < 87) cmd = CMD_STOP;
          else if (r < 93) cmd = CMD_RESET;
          else if (r < 97) cmd = CMD_INIT;
          else             cmd = CMD_RELEASE;
        end else begin
          if (r < 30)      cmd = CMD_POLL;
          else if (r < 45) cmd = CMD_READ_US;
          else if (r < 60) cmd = CMD_READ_MS;
          else if (r < 72) cmd = CMD_STOP;
          else if (r < 78) cmd = CMD_RESET;
          else if (r < 83) cmd = CMD_QUERY_RUN;
          else if (r < 88) cmd = CMD_START;
          else if (r < 92) cmd = CMD_INIT;
          else if (r < 95) cmd = CMD_RELEASE;
          else             cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
      end
      issue_request(cmd, tick, 1'b0, NO_REPLY);
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow a little longer for anything stray
    while (replies_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ews_pkg.sv
src/ews_req_if.sv
src/ews_rsp_if.sv
src/ews_front.sv
src/ews_exec.sv
src/ews_div.sv
src/wrap_extending_stopwatch_64_core.sv
src/ews_check.sv
tb/testbench.sv
